FILE: sv/rdcb_pkg.sv
// ----------------------------------------------------------------------------
// rdcb_pkg
// Shared types, codes and constants of the register-DMA command builder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdcb_pkg;

  localparam int unsigned IdxW  = 14;
  localparam int unsigned WordW = 32;

  localparam logic [IdxW-1:0] BufSizeReset = 14'd128;

  localparam logic [31:0] DecodeSelWord = 32'h180A_C060;
  localparam logic [31:0] OpcSingle     = 32'h1000_0000;
  localparam logic [31:0] OpcAutoInc    = 32'h4000_0000;
  localparam logic [31:0] OpcIndexed    = 32'h3000_0000;
  localparam logic [31:0] OpcLut        = 32'h5000_0000;

  localparam logic [1:0] NaSelect = 2'b01;
  localparam logic [1:0] NaWrite  = 2'b10;
  localparam logic [1:0] NaBoth   = 2'b11;
  localparam logic [1:0] OpsBoth  = 2'b11;

  localparam logic [4:0] TrigQueue0 = 5'd1;
  localparam logic [4:0] TrigQueue1 = 5'd16;

  typedef enum logic [2:0] {
    OP_SELECT  = 3'd0,
    OP_SINGLE  = 3'd1,
    OP_AUTOINC = 3'd2,
    OP_INDEXED = 3'd3,
    OP_LUT     = 3'd4,
    OP_PAYLOAD = 3'd5,
    OP_RESET   = 3'd6,
    OP_KICK    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SEQ        = 4'd1,
    ST_SPACE      = 4'd2,
    ST_BLOCK      = 4'd3,
    ST_UNSUP      = 4'd4,
    ST_ALIGN      = 4'd5,
    ST_WRAP       = 4'd6,
    ST_INCOMPLETE = 4'd7,
    ST_PAYLOAD    = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    KIND_BUF    = 2'd0,
    KIND_KICK   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  localparam logic [2:0] FeatGamut = 3'd0;
  localparam logic [2:0] FeatVlut  = 3'd1;
  localparam logic [2:0] FeatGc    = 3'd2;
  localparam logic [2:0] FeatIgc   = 3'd3;
  localparam logic [2:0] FeatPcc   = 3'd4;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [1:0]       kind;
    logic [3:0]       status;
    logic [4:0]       trig;
    logic             two;
  } job_t;

  // Blocks that support each feature; unsupported features map to none.
  function automatic logic [9:0] feature_blocks(input logic [2:0] feat);
    logic [9:0] r;
    r = 10'h000;
    case (feat)
      FeatGamut: r = 10'h0FF;
      FeatVlut:  r = 10'h0F0;
      FeatGc:    r = 10'h0F0;
      FeatIgc:   r = 10'h2F0;
      FeatPcc:   r = 10'h0F0;
      default:   r = 10'h000;
    endcase
    return r;
  endfunction

  // Spreads the block mask into the hardware select word layout.
  function automatic logic [31:0] decode_select(input logic [9:0] mask);
    logic [31:0] d;
    d = '0;
    d[3:0]   = mask[3:0];
    d[20:17] = mask[7:4];
    d[4]     = mask[8];
    d[21]    = mask[9];
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rdcb_front.sv
// ----------------------------------------------------------------------------
// rdcb_front
// Accepts requests, checks them against the builder state and emits one job.
// ----------------------------------------------------------------------------
`default_nettype none

module rdcb_front import rdcb_pkg::*; #(
  parameter int MAX_BUFFER_DWORDS = 16383
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [IdxW-1:0]  buf_size_i,
  input  wire logic [2:0]       op_i,
  input  wire logic [9:0]       block_mask_i,
  input  wire logic [2:0]       feature_i,
  input  wire logic [19:0]      reg_offset_i,
  input  wire logic [13:0]      dword_count_i,
  input  wire logic [3:0]       lut_wrap_i,
  input  wire logic             increment_i,
  input  wire logic [31:0]      data_word_i,
  input  wire logic             read_mode_i,
  input  wire logic [1:0]       hist_select_i,
  input  wire logic             last_cmd_i,
  input  wire logic             dma_queue_i,
  output job_t                  job_o
);

  localparam logic [IdxW-1:0] MaxDw = IdxW'(MAX_BUFFER_DWORDS);

  logic [IdxW-1:0] write_index_q, write_index_d;
  logic [1:0]      next_allowed_q, next_allowed_d;
  logic [1:0]      ops_done_q, ops_done_d;
  logic [13:0]     payload_left_q, payload_left_d;

  logic [IdxW-1:0] size_eff;
  logic [14:0]     need;
  logic [15:0]     end_pos;
  logic            no_room;
  logic            seq_ok;
  logic [31:0]     kick_cmd;
  op_e             op;

  assign op       = op_e'(op_i);
  assign size_eff = (buf_size_i > MaxDw) ? MaxDw : buf_size_i;
  assign need     = (op == OP_SELECT || op == OP_SINGLE) ? 15'd2
                                                         : 15'd2 + {1'b0, dword_count_i};
  assign end_pos  = {2'b00, write_index_q} + {1'b0, need};
  assign no_room  = end_pos > {2'b00, size_eff};
  assign seq_ok   = (op == OP_SELECT) ? next_allowed_q[0] : next_allowed_q[1];

  always_comb begin
    kick_cmd = read_mode_i ? ({hist_select_i, 30'd0} | (32'd2 << 22)) : (32'd1 << 22);
    if (last_cmd_i) begin
      kick_cmd = kick_cmd | (32'd1 << 24);
    end
    kick_cmd = kick_cmd | {18'd0, write_index_q};
  end

  always_comb begin
    job_o          = '0;
    job_o.idx      = write_index_q;
    job_o.kind     = KIND_STATUS;
    job_o.status   = ST_OK;
    write_index_d  = write_index_q;
    next_allowed_d = next_allowed_q;
    ops_done_d     = ops_done_q;
    payload_left_d = payload_left_q;
    case (op)
      OP_RESET: begin
        job_o.idx      = '0;
        write_index_d  = '0;
        next_allowed_d = NaSelect;
        ops_done_d     = '0;
        payload_left_d = '0;
      end
      OP_PAYLOAD: begin
        if (payload_left_q == '0) begin
          job_o.status = ST_PAYLOAD;
        end else begin
          job_o.kind     = KIND_BUF;
          job_o.w0       = data_word_i;
          write_index_d  = write_index_q + 14'd1;
          payload_left_d = payload_left_q - 14'd1;
        end
      end
      OP_KICK: begin
        if (payload_left_q != '0 || write_index_q == '0 ||
            (!read_mode_i && ops_done_q != OpsBoth)) begin
          job_o.status = ST_INCOMPLETE;
        end else begin
          job_o.kind = KIND_KICK;
          job_o.w0   = kick_cmd;
          job_o.trig = last_cmd_i ? (dma_queue_i ? TrigQueue1 : TrigQueue0) : 5'd0;
        end
      end
      default: begin
        if (payload_left_q != '0) begin
          job_o.status = ST_SEQ;
        end else if ((block_mask_i & feature_blocks(feature_i)) == '0) begin
          job_o.status = ST_UNSUP;
        end else if (write_index_q >= size_eff) begin
          job_o.status = ST_SPACE;
        end else if (!seq_ok) begin
          job_o.status = ST_SEQ;
        end else if (no_room) begin
          job_o.status = ST_SPACE;
        end else if (op == OP_SELECT) begin
          if (block_mask_i == '0 || (block_mask_i[3:0] != '0 && block_mask_i[7:4] != '0)) begin
            job_o.status = ST_BLOCK;
          end else begin
            job_o.kind     = KIND_BUF;
            job_o.two      = 1'b1;
            job_o.w0       = DecodeSelWord;
            job_o.w1       = decode_select(block_mask_i);
            write_index_d  = write_index_q + 14'd2;
            ops_done_d     = ops_done_q | NaSelect;
            next_allowed_d = NaWrite;
          end
        end else if (reg_offset_i[1:0] != 2'b00) begin
          job_o.status = ST_ALIGN;
        end else if (op == OP_LUT && lut_wrap_i < 4'd2) begin
          job_o.status = ST_WRAP;
        end else begin
          job_o.kind     = KIND_BUF;
          job_o.two      = 1'b1;
          write_index_d  = write_index_q + 14'd2;
          ops_done_d     = ops_done_q | NaWrite;
          next_allowed_d = NaBoth;
          payload_left_d = (op == OP_SINGLE) ? 14'd0 : dword_count_i;
          case (op)
            OP_SINGLE: begin
              job_o.w0 = OpcSingle | {12'd0, reg_offset_i};
              job_o.w1 = data_word_i;
            end
            OP_AUTOINC: begin
              job_o.w0 = OpcAutoInc | {12'd0, reg_offset_i};
              job_o.w1 = {18'd0, dword_count_i};
            end
            OP_INDEXED: begin
              job_o.w0 = OpcIndexed | {12'd0, reg_offset_i};
              job_o.w1 = {18'd0, dword_count_i};
            end
            default: begin
              job_o.w0 = OpcLut | {12'd0, reg_offset_i};
              job_o.w1 = {~increment_i, 11'd0, lut_wrap_i, 2'b00, dword_count_i};
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q  <= '0;
      next_allowed_q <= NaSelect;
      ops_done_q     <= '0;
      payload_left_q <= '0;
    end else if (accept_i) begin
      write_index_q  <= write_index_d;
      next_allowed_q <= next_allowed_d;
      ops_done_q     <= ops_done_d;
      payload_left_q <= payload_left_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rdcb_fifo.sv
// ----------------------------------------------------------------------------
// rdcb_fifo
// Two-entry job queue between the request front and the word back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rdcb_fifo import rdcb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      head_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/rdcb_back.sv
// ----------------------------------------------------------------------------
// rdcb_back
// Holds one job and sends its one or two result words on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rdcb_back import rdcb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         job_valid_i,
  input  wire job_t         job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [IdxW-1:0]   word_index_o,
  output logic [WordW-1:0]  word_o,
  output logic [1:0]        kind_o,
  output logic [3:0]        status_o,
  output logic [4:0]        trigger_bits_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    S_EMPTY  = 3'b001,
    S_FIRST  = 3'b010,
    S_SECOND = 3'b100
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;
  logic   out_take;

  assign out_valid_o    = state_q != S_EMPTY;
  assign last_o         = (state_q == S_SECOND) || (state_q == S_FIRST && !job_q.two);
  assign word_index_o   = (state_q == S_SECOND) ? job_q.idx + 14'd1 : job_q.idx;
  assign word_o         = (state_q == S_SECOND) ? job_q.w1 : job_q.w0;
  assign kind_o         = job_q.kind;
  assign status_o       = job_q.status;
  assign trigger_bits_o = job_q.trig;

  assign out_take = out_valid_o && out_ready_i;
  assign pop_o    = job_valid_i && (state_q == S_EMPTY || (out_take && last_o));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_EMPTY: begin
        if (pop_o) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST, S_SECOND: begin
        if (out_take) begin
          if (!last_o) begin
            state_d = S_SECOND;
          end else if (pop_o) begin
            state_d = S_FIRST;
          end else begin
            state_d = S_EMPTY;
          end
        end
      end
      default: state_d = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/register_dma_command_builder.sv
// ----------------------------------------------------------------------------
// register_dma_command_builder
// Builds a register-DMA command list from requests and emits buffer words.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   in        sink       in_valid_i/in_ready_o  one request or payload word
//   out       source     out_valid_o/out_ready_i one emitted word or status
//   cfg       sink       cfg_valid_i/cfg_ready_o buffer size in words
//
// The front takes one request per cycle whenever the two-entry job queue has
// room; it checks the request and updates the list state in that same cycle.
// The back end sends one result word per cycle while out_ready_i is high, so a
// header request yields two words and every other request one.
// Reset is asynchronous: the list state clears and the buffer size is 128.
// A stall on the output fills the queue, after which in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module register_dma_command_builder import rdcb_pkg::*; #(
  parameter int MAX_BUFFER_DWORDS = 16383
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [13:0] cfg_data_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [9:0]  block_mask_i,
  input  wire logic [2:0]  feature_i,
  input  wire logic [19:0] reg_offset_i,
  input  wire logic [13:0] dword_count_i,
  input  wire logic [3:0]  lut_wrap_i,
  input  wire logic        increment_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic        read_mode_i,
  input  wire logic [1:0]  hist_select_i,
  input  wire logic        last_cmd_i,
  input  wire logic        dma_queue_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [13:0]      word_index_o,
  output logic [31:0]      word_o,
  output logic [1:0]       kind_o,
  output logic [3:0]       status_o,
  output logic [4:0]       trigger_bits_o,
  output logic             last_o
);

  logic [IdxW-1:0] buf_size_q;
  logic            in_accept;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  job_t            front_job;
  job_t            q_head;

  // The size register is always writable; software must ensure it only writes it while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BufSizeReset;
    end else if (cfg_valid_i) begin
      buf_size_q <= cfg_data_i;
    end
  end

  // A request is taken whenever the queue can hold its job.
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  rdcb_front #(
    .MAX_BUFFER_DWORDS(MAX_BUFFER_DWORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .buf_size_i     (buf_size_q),
    .op_i           (op_i),
    .block_mask_i   (block_mask_i),
    .feature_i      (feature_i),
    .reg_offset_i   (reg_offset_i),
    .dword_count_i  (dword_count_i),
    .lut_wrap_i     (lut_wrap_i),
    .increment_i    (increment_i),
    .data_word_i    (data_word_i),
    .read_mode_i    (read_mode_i),
    .hist_select_i  (hist_select_i),
    .last_cmd_i     (last_cmd_i),
    .dma_queue_i    (dma_queue_i),
    .job_o          (front_job)
  );

  rdcb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // The back end expands each job into its header, payload, kick or status words.
  rdcb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_index_o   (word_index_o),
    .word_o         (word_o),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .trigger_bits_o (trigger_bits_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
